/* rtl/gsr_pkg.sv */
// ----------------------------------------------------------------------------
// gsr_pkg: shared types and constants of the rank classifier
// Widths of the fixed point datapath, cell commands and the result word.
// ----------------------------------------------------------------------------
package gsr_pkg;

  localparam int ELEM_W     = 32;   // loaded element, signed q8.24
  localparam int TAG_W      = 15;   // row tag
  localparam int V_W        = 40;   // working element, signed, saturated
  localparam int MAG_W      = 39;   // magnitude of a working element
  localparam int FRAC_W     = 24;   // fraction bits
  localparam int MA_W       = 45;   // multiplicand width (dot magnitude)
  localparam int SUM_W      = 84;   // products and chain sums
  localparam int Q_W        = 25;   // magnitude of a normalized element
  localparam int ROOT_W     = 43;   // square root and divisor
  localparam int PDIFF_W    = 47;   // projection difference before saturation
  localparam int DIV_STEPS  = MAG_W + FRAC_W;
  localparam int MUL_STEPS  = MAG_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIM_W      = 7;
  localparam int EC_W       = 5;
  localparam int CNT_W      = 7;
  localparam int RC_W       = 16;

  localparam logic [SUM_W-1:0] NORM_SQ_MIN = SUM_W'(282);
  localparam logic [Q_W-1:0] INDEP_LIMIT = Q_W'(167);
  localparam logic [SUM_W-1:0] DOT_LIMIT = SUM_W'(64'd16777216000000);
  localparam logic signed [PDIFF_W-1:0] VMAX = PDIFF_W'(64'sd549755813887);

  typedef struct packed {
    logic [4:0]  dimension;
    logic [13:0] total_threshold;
    logic [13:0] column_count;
    logic [13:0] row_count;
    logic [13:0] initial_residual_count;
  } cfg_t;

  typedef enum logic [3:0] {
    C_IDLE,
    C_LOAD,
    C_SQ_START,
    C_DOT_START,
    C_PROJ_START,
    C_MUL_STEP,
    C_SQ_SUM,
    C_DOT_SUM,
    C_SHIFT,
    C_DIV_START,
    C_DIV_STEP,
    C_DIV_END,
    C_PROJ_WR
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [ELEM_W-1:0]  elem;
    logic [EC_W-1:0]    ecount;
    logic               load_elem;
    logic               clear;
    logic [DIM_W-1:0]   dim_eff;
    logic               zero;
    logic [ROOT_W-1:0]  root;
    logic [MA_W-1:0]    smag;
    logic               sneg;
  } cell_ctl_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  vector_position;
    logic [14:0] tag_out;
    logic        independent;
    logic        is_residual;
    logic [3:0]  residual_index;
    logic        in_basis;
    logic [15:0] basis_index;
    logic [14:0] residual_count;
    logic [14:0] new_row_count;
    logic [14:0] new_col_count;
    logic        last;
  } result_t;

endpackage

/* rtl/gsr_ram.sv */
// ----------------------------------------------------------------------------
// gsr_ram: generic single write port ram
// One write and one read address per cycle, registered read data.
// ----------------------------------------------------------------------------
module gsr_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/gsr_cell.sv */
// ----------------------------------------------------------------------------
// gsr_cell: one element column of the vector set
// Holds element IDX of every vector, with a bit-serial multiplier, a
// restoring divider and one stage of the sum shift chain.
// ----------------------------------------------------------------------------
module gsr_cell import gsr_pkg::*; #(
  parameter int IDX = 0,
  parameter int MAX_VECTORS = 16,
  localparam int AW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [AW-1:0]    addr,
  input  logic [SUM_W-1:0] carry_in,
  output logic [SUM_W-1:0] carry,
  output logic             indep
);

  logic                       en;
  logic                       at_ec;
  logic                       we;
  logic [V_W-1:0]             wdata;
  logic [V_W-1:0]             dout;
  logic [V_W-1:0]             dabs;
  logic [MAG_W-1:0]           dmag;

  logic [MA_W-1:0]            ma;
  logic [MAG_W-1:0]           mb;
  logic [SUM_W-1:0]           acc;
  logic [SUM_W-1:0]           acc_next;
  logic                       vneg;
  logic signed [V_W-1:0]      vcur;
  logic [DIV_STEPS-1:0]       dvd;
  logic [ROOT_W-1:0]          rem;
  logic [ROOT_W-1:0]          rem_next;
  logic [ROOT_W:0]            remx;
  logic [ROOT_W:0]            rem_sub;
  logic                       ge;
  logic [Q_W-1:0]             qsh;
  logic [Q_W-1:0]             qmag;
  logic                       qneg;

  logic [SUM_W-1:0]           tz;
  logic [SUM_W-1:0]           dterm;
  logic [MA_W-1:0]            p;
  logic signed [PDIFF_W-1:0]  vx;
  logic signed [PDIFF_W-1:0]  px;
  logic signed [PDIFF_W-1:0]  diff;
  logic [V_W-1:0]             vsat;

  assign en    = DIM_W'(IDX) < ctl.dim_eff;
  assign at_ec = DIM_W'(IDX) == DIM_W'(ctl.ecount);

  assign dabs = dout[V_W-1] ? (~dout + 1'b1) : dout;
  assign dmag = dabs[MAG_W-1:0];

  // msb-first shift and add
  assign acc_next = {acc[SUM_W-2:0], 1'b0} + (mb[MAG_W-1] ? SUM_W'(ma) : '0);

  // restoring division step
  assign remx     = {rem, dvd[DIV_STEPS-1]};
  assign rem_sub  = remx - {1'b0, ctl.root};
  assign ge       = remx >= {1'b0, ctl.root};
  assign rem_next = ge ? rem_sub[ROOT_W-1:0] : remx[ROOT_W-1:0];

  // signed dot term
  assign tz    = SUM_W'(acc[FRAC_W +: V_W]);
  assign dterm = (vneg ^ qneg) ? (~tz + 1'b1) : tz;

  // projection and saturating subtract
  assign p    = acc[FRAC_W +: MA_W];
  assign vx   = PDIFF_W'(vcur);
  assign px   = $signed({2'b00, p});
  assign diff = (ctl.sneg ^ qneg) ? (vx + px) : (vx - px);
  always_comb begin
    if (diff > VMAX) begin
      vsat = V_W'(VMAX);
    end else if (diff < -VMAX) begin
      vsat = V_W'(-VMAX);
    end else begin
      vsat = diff[V_W-1:0];
    end
  end

  always_comb begin
    we    = 1'b0;
    wdata = vsat;
    case (ctl.op)
      C_LOAD: begin
        if (ctl.load_elem && at_ec) begin
          we    = 1'b1;
          wdata = {{(V_W-ELEM_W){ctl.elem[ELEM_W-1]}}, ctl.elem};
        end else if (ctl.clear && (DIM_W'(IDX) >= DIM_W'(ctl.ecount))) begin
          we    = 1'b1;
          wdata = '0;
        end
      end
      C_PROJ_WR: we = en;
      default: ;
    endcase
  end

  gsr_ram #(.WIDTH(V_W), .DEPTH(MAX_VECTORS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (dout)
  );

  always_ff @(posedge clk) begin
    case (ctl.op)
      C_SQ_START: begin
        ma  <= MA_W'(dmag);
        mb  <= dmag;
        acc <= '0;
      end
      C_DOT_START: begin
        ma   <= MA_W'(dmag);
        mb   <= MAG_W'(qmag);
        acc  <= '0;
        vneg <= dout[V_W-1];
        vcur <= dout;
      end
      C_PROJ_START: begin
        ma  <= ctl.smag;
        mb  <= MAG_W'(qmag);
        acc <= '0;
      end
      C_MUL_STEP: begin
        acc <= acc_next;
        mb  <= {mb[MAG_W-2:0], 1'b0};
      end
      C_SQ_SUM:  carry <= en ? acc : '0;
      C_DOT_SUM: carry <= en ? dterm : '0;
      C_SHIFT:   carry <= carry_in;
      C_DIV_START: begin
        dvd  <= {dmag, {FRAC_W{1'b0}}};
        rem  <= '0;
        qsh  <= '0;
        vneg <= dout[V_W-1];
      end
      C_DIV_STEP: begin
        rem <= rem_next;
        dvd <= {dvd[DIV_STEPS-2:0], 1'b0};
        qsh <= {qsh[Q_W-2:0], ge};
      end
      C_DIV_END: begin
        if (en && !ctl.zero) begin
          qmag  <= qsh;
          qneg  <= vneg && (qsh != '0);
          indep <= qsh > INDEP_LIMIT;
        end else begin
          qmag  <= '0;
          qneg  <= 1'b0;
          indep <= 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/gsr_ctrl.sv */
// ----------------------------------------------------------------------------
// gsr_ctrl: sequencer of the rank classifier
// Load counters, tags, the cell command sequence, square root, per-vector
// flags and the result word register.
// ----------------------------------------------------------------------------
module gsr_ctrl import gsr_pkg::*; #(
  parameter int MAX_VECTORS = 16,
  parameter int MAX_DIM = 16,
  localparam int AW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1,
  localparam int VCW = $clog2(MAX_VECTORS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              s_valid,
  output logic              s_ready,
  input  logic [ELEM_W-1:0] in_elem,
  input  logic [TAG_W-1:0]  in_tag,
  input  logic              in_vend,
  input  logic              in_send,
  input  logic [SUM_W-1:0]  carry0,
  input  logic              indep_any,
  output cell_ctl_t         ctl,
  output logic [AW-1:0]     addr,
  output logic              m_valid,
  input  logic              m_ready,
  output result_t           m_word
);

  typedef enum logic [4:0] {
    S_LOAD, S_VEC, S_SQ_RD, S_SQ_MUL, S_SQ_SUM, S_SQ_SH, S_SQ_WAIT, S_SQ_CHK,
    S_SQRT, S_DIV_GO, S_DIV, S_DIV_END, S_DIV_DONE, S_ROW, S_DOT_RD, S_DOT_MUL,
    S_DOT_SUM, S_DOT_SH, S_DOT_WAIT, S_DOT_CHK, S_PROJ_MUL, S_PROJ_WR, S_IND,
    S_OUT
  } state_t;

  state_t state;

  logic [VCW-1:0]   vc, n, i, j, oi, nres, ridx;
  logic [EC_W-1:0]  ec;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] sum;
  logic [2*ROOT_W-1:0] sqv;
  logic [ROOT_W+1:0]   srem;
  logic [ROOT_W-1:0]   root;
  logic [TAG_W-1:0] tags [MAX_VECTORS];
  logic [MAX_VECTORS-1:0] indep_bits;
  logic [MAX_VECTORS-1:0] resid_bits;

  logic [DIM_W-1:0] dim_eff;
  logic             full;
  logic             vend_any;
  logic             load_elem;
  logic [AW-1:0]    tix;
  logic [TAG_W-1:0] tag_rd;
  logic             resid_now;
  logic [ROOT_W+3:0] sq_remx;
  logic [ROOT_W+3:0] sq_trial;
  logic             sq_ge;
  logic [ROOT_W+3:0] sq_diff;
  logic             sneg;
  logic [SUM_W-1:0] smag;
  logic [RC_W-1:0]  rcnt;
  logic [RC_W-1:0]  bsum;
  logic [RC_W-1:0]  nrow;
  logic [RC_W-1:0]  ncol;
  logic             o_indep;
  logic             o_basis;
  result_t          vec_word;
  result_t          sum_word;

  assign dim_eff = (DIM_W'(cfg.dimension) > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                            : DIM_W'(cfg.dimension);
  assign full      = vc == VCW'(MAX_VECTORS);
  assign vend_any  = in_vend || in_send;
  assign load_elem = DIM_W'(ec) < dim_eff;
  assign s_ready   = state == S_LOAD;

  assign tix       = (state == S_OUT) ? oi[AW-1:0] : i[AW-1:0];
  assign tag_rd    = tags[tix];
  assign resid_now = indep_any && (tag_rd >= TAG_W'(cfg.total_threshold));

  // digit-by-digit square root, two radicand bits per step
  assign sq_remx  = {srem, sqv[2*ROOT_W-1 -: 2]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign sq_ge    = sq_remx >= sq_trial;
  assign sq_diff  = sq_remx - sq_trial;

  assign sneg = sum[SUM_W-1];
  assign smag = sneg ? (~sum + 1'b1) : sum;

  always_comb begin
    rcnt    = RC_W'(cfg.initial_residual_count) + RC_W'(nres);
    bsum    = RC_W'(tag_rd) + rcnt;
    nrow    = RC_W'(cfg.row_count) + rcnt;
    ncol    = RC_W'(cfg.column_count) + rcnt;
    o_indep = indep_bits[oi[AW-1:0]];
    o_basis = !o_indep && (tag_rd < TAG_W'(cfg.total_threshold));

    vec_word                 = '0;
    vec_word.vector_position = 4'(oi);
    vec_word.tag_out         = tag_rd;
    vec_word.independent     = o_indep;
    vec_word.is_residual     = resid_bits[oi[AW-1:0]];
    vec_word.residual_index  = resid_bits[oi[AW-1:0]] ? 4'(ridx) : 4'd0;
    vec_word.in_basis        = o_basis;
    if (o_basis) begin
      vec_word.basis_index = (tag_rd >= TAG_W'(cfg.column_count)) ? bsum : RC_W'(tag_rd);
    end

    sum_word                = '0;
    sum_word.kind           = 1'b1;
    sum_word.residual_count = rcnt[14:0];
    sum_word.new_row_count  = nrow[14:0];
    sum_word.new_col_count  = ncol[14:0];
    sum_word.last           = 1'b1;
  end

  always_ff @(posedge clk) begin
    ctl.op      <= C_IDLE;
    ctl.dim_eff <= dim_eff;
    if (ctl.op == C_SHIFT) begin
      sum <= sum + carry0;
    end

    if (rst) begin
      state   <= S_LOAD;
      vc      <= '0;
      ec      <= '0;
      m_valid <= 1'b0;
    end else begin
      // outside the output phase a taken word just empties the register
      if (m_valid && m_ready && state != S_OUT) begin
        m_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (s_valid) begin
            if (!full) begin
              ctl.op        <= C_LOAD;
              ctl.elem      <= in_elem;
              ctl.ecount    <= ec;
              ctl.load_elem <= load_elem;
              ctl.clear     <= vend_any;
              addr          <= vc[AW-1:0];
              tags[vc[AW-1:0]] <= in_tag;
            end
            if (vend_any) begin
              ec <= '0;
            end else if (!full && load_elem) begin
              ec <= ec + 1'b1;
            end
            if (!full && vend_any) begin
              vc <= vc + 1'b1;
            end
            if (in_send) begin
              n     <= full ? vc : vc + 1'b1;
              vc    <= '0;
              i     <= '0;
              nres  <= '0;
              state <= S_VEC;
            end
          end
        end
        S_VEC: begin
          if (i == n) begin
            oi    <= '0;
            ridx  <= '0;
            state <= S_OUT;
          end else begin
            addr  <= i[AW-1:0];
            state <= S_SQ_RD;
          end
        end
        S_SQ_RD: begin
          ctl.op <= C_SQ_START;
          cnt    <= '0;
          state  <= S_SQ_MUL;
        end
        S_SQ_MUL: begin
          ctl.op <= C_MUL_STEP;
          cnt    <= cnt + 1'b1;
          if (cnt == CNT_W'(MUL_STEPS - 1)) begin
            state <= S_SQ_SUM;
          end
        end
        S_SQ_SUM: begin
          ctl.op <= C_SQ_SUM;
          sum    <= '0;
          cnt    <= '0;
          state  <= S_SQ_SH;
        end
        S_SQ_SH: begin
          ctl.op <= C_SHIFT;
          cnt    <= cnt + 1'b1;
          if (cnt == CNT_W'(MAX_DIM - 1)) begin
            state <= S_SQ_WAIT;
          end
        end
        S_SQ_WAIT: state <= S_SQ_CHK;
        S_SQ_CHK: begin
          if (sum < NORM_SQ_MIN) begin
            ctl.op   <= C_DIV_END;
            ctl.zero <= 1'b1;
            state    <= S_DIV_DONE;
          end else begin
            ctl.zero <= 1'b0;
            sqv      <= {2'b00, sum};
            srem     <= '0;
            root     <= '0;
            cnt      <= '0;
            state    <= S_SQRT;
          end
        end
        S_SQRT: begin
          sqv  <= {sqv[2*ROOT_W-3:0], 2'b00};
          srem <= sq_ge ? sq_diff[ROOT_W+1:0] : sq_remx[ROOT_W+1:0];
          root <= {root[ROOT_W-2:0], sq_ge};
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_W'(SQRT_STEPS - 1)) begin
            state <= S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          ctl.root <= root;
          ctl.op   <= C_DIV_START;
          cnt      <= '0;
          state    <= S_DIV;
        end
        S_DIV: begin
          ctl.op <= C_DIV_STEP;
          cnt    <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= S_DIV_END;
          end
        end
        S_DIV_END: begin
          ctl.op <= C_DIV_END;
          state  <= S_DIV_DONE;
        end
        S_DIV_DONE: begin
          j     <= i + 1'b1;
          state <= S_ROW;
        end
        S_ROW: begin
          if (j >= n) begin
            state <= S_IND;
          end else begin
            addr  <= j[AW-1:0];
            state <= S_DOT_RD;
          end
        end
        S_DOT_RD: begin
          ctl.op <= C_DOT_START;
          cnt    <= '0;
          state  <= S_DOT_MUL;
        end
        S_DOT_MUL: begin
          ctl.op <= C_MUL_STEP;
          cnt    <= cnt + 1'b1;
          if (cnt == CNT_W'(MUL_STEPS - 1)) begin
            state <= S_DOT_SUM;
          end
        end
        S_DOT_SUM: begin
          ctl.op <= C_DOT_SUM;
          sum    <= '0;
          cnt    <= '0;
          state  <= S_DOT_SH;
        end
        S_DOT_SH: begin
          ctl.op <= C_SHIFT;
          cnt    <= cnt + 1'b1;
          if (cnt == CNT_W'(MAX_DIM - 1)) begin
            state <= S_DOT_WAIT;
          end
        end
        S_DOT_WAIT: state <= S_DOT_CHK;
        S_DOT_CHK: begin
          if (smag > DOT_LIMIT) begin
            // dot product too large, row j is left as it is
            j     <= j + 1'b1;
            state <= S_ROW;
          end else begin
            ctl.smag <= smag[MA_W-1:0];
            ctl.sneg <= sneg;
            ctl.op   <= C_PROJ_START;
            cnt      <= '0;
            state    <= S_PROJ_MUL;
          end
        end
        S_PROJ_MUL: begin
          ctl.op <= C_MUL_STEP;
          cnt    <= cnt + 1'b1;
          if (cnt == CNT_W'(MUL_STEPS - 1)) begin
            state <= S_PROJ_WR;
          end
        end
        S_PROJ_WR: begin
          ctl.op <= C_PROJ_WR;
          j      <= j + 1'b1;
          state  <= S_ROW;
        end
        S_IND: begin
          indep_bits[i[AW-1:0]] <= indep_any;
          resid_bits[i[AW-1:0]] <= resid_now;
          if (resid_now) begin
            nres <= nres + 1'b1;
          end
          i     <= i + 1'b1;
          state <= S_VEC;
        end
        S_OUT: begin
          if (!m_valid || m_ready) begin
            m_valid <= 1'b1;
            if (oi < n) begin
              m_word <= vec_word;
              if (resid_bits[oi[AW-1:0]]) begin
                ridx <= ridx + 1'b1;
              end
              oi <= oi + 1'b1;
            end else begin
              m_word <= sum_word;
              state  <= S_LOAD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

/* rtl/gram_schmidt_rank_classifier.sv */
// ----------------------------------------------------------------------------
// gram_schmidt_rank_classifier: modified gram-schmidt rank classifier
// Loads up to MAX_VECTORS q8.24 vectors, orthonormalizes them in load order
// and reports per vector whether it is independent, a residual or part of
// the starting basis, followed by a summary word of updated counts.
//
//   channel   dir  words                       fields
//   s_*       in   one element                 element, row_tag, vector_end,
//                                              set_end
//   m_*       out  one result per vector + 1   kind, result fields, last
//   apb       in   register write / read       five configuration registers
//
// loading takes one word per cycle while the block is in its load phase
// compute time per vector grows with the number of later vectors and is set by
// the 39-step bit-serial multiplier, the 63-step divider in each cell and
// the 43-step square root in the sequencer
// the result words then leave one per cycle when m_tready is high
// rst is synchronous; it empties the load counters and the result register
// s_tready is low from the set end word until the summary word is loaded
// ----------------------------------------------------------------------------
module gram_schmidt_rank_classifier import gsr_pkg::*; #(
  parameter int MAX_VECTORS = 16,
  parameter int MAX_DIM = 16
) (
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // element[31:0], row_tag[46:32], zero[47]
  input  logic        s_tlast,   // vector_end
  input  logic        s_tuser,   // set_end
  // stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // vector_position[3:0], tag_out[18:4],
                                 // independent[19], is_residual[20],
                                 // residual_index[24:21], in_basis[25],
                                 // basis_index[41:26], residual_count[56:42],
                                 // new_row_count[71:57], new_col_count[86:72],
                                 // zero[87]
  output logic        m_tuser,   // kind
  output logic        m_tlast,   // last
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;

  typedef enum logic [2:0] {
    REG_DIMENSION, REG_THRESHOLD, REG_COLUMNS, REG_ROWS, REG_RESIDUALS
  } reg_idx_t;

  cfg_t             cfg;
  reg_idx_t         ridx;
  logic             wr;
  cell_ctl_t        ctl;
  logic [AW-1:0]    addr;
  logic [SUM_W-1:0] carry [MAX_DIM+1];
  logic [MAX_DIM-1:0] indep;
  result_t          word;

  // apb registers, one per word address
  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dimension              <= 5'd16;
      cfg.total_threshold        <= '0;
      cfg.column_count           <= '0;
      cfg.row_count              <= '0;
      cfg.initial_residual_count <= '0;
    end else if (wr) begin
      unique case (ridx)
        REG_DIMENSION: cfg.dimension              <= pwdata[4:0];
        REG_THRESHOLD: cfg.total_threshold        <= pwdata[13:0];
        REG_COLUMNS:   cfg.column_count           <= pwdata[13:0];
        REG_ROWS:      cfg.row_count              <= pwdata[13:0];
        REG_RESIDUALS: cfg.initial_residual_count <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_DIMENSION: prdata = 32'(cfg.dimension);
      REG_THRESHOLD: prdata = 32'(cfg.total_threshold);
      REG_COLUMNS:   prdata = 32'(cfg.column_count);
      REG_ROWS:      prdata = 32'(cfg.row_count);
      REG_RESIDUALS: prdata = 32'(cfg.initial_residual_count);
      default:       prdata = '0;
    endcase
  end

  gsr_ctrl #(.MAX_VECTORS(MAX_VECTORS), .MAX_DIM(MAX_DIM)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_valid   (s_tvalid),
    .s_ready   (s_tready),
    .in_elem   (s_tdata[31:0]),
    .in_tag    (s_tdata[46:32]),
    .in_vend   (s_tlast),
    .in_send   (s_tuser),
    .carry0    (carry[0]),
    .indep_any (|indep),
    .ctl       (ctl),
    .addr      (addr),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_word    (word)
  );

  // the chain of cells; partial sums shift toward cell 0
  assign carry[MAX_DIM] = '0;

  for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
    gsr_cell #(.IDX(k), .MAX_VECTORS(MAX_VECTORS)) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .addr     (addr),
      .carry_in (carry[k+1]),
      .carry    (carry[k]),
      .indep    (indep[k])
    );
  end

  assign m_tuser = word.kind;
  assign m_tlast = word.last;
  assign m_tdata = {1'b0, word.new_col_count, word.new_row_count, word.residual_count,
                    word.basis_index, word.in_basis, word.residual_index,
                    word.is_residual, word.independent, word.tag_out,
                    word.vector_position};

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for the gram-schmidt rank classifier
// Streams tagged vectors into the block, runs a bit-exact fixed point model of
// modified gram-schmidt on every accepted word and checks each result word
// and summary word in order, with random idling on both streams.
// ----------------------------------------------------------------------------
module tb;
  import gsr_pkg::*;

  localparam int NVEC = 16;
  localparam int NDIM = 16;

  // register indexes, byte address is 4 * index
  localparam int REG_DIMENSION = 0;
  localparam int REG_TOTAL_THRESHOLD = 1;
  localparam int REG_COLUMN_COUNT = 2;
  localparam int REG_ROW_COUNT = 3;
  localparam int REG_INIT_RESIDUALS = 4;

  localparam longint VSAT = 64'sd549755813887;
  localparam longint unsigned NORM_FLOOR = 282;
  localparam longint unsigned INDEP_FLOOR = 167;
  localparam longint unsigned DOT_CEIL = 64'd16777216000000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // element[31:0], row_tag[46:32], zero[47]
  logic        s_tlast;   // vector_end
  logic        s_tuser;   // set_end
  logic        m_tvalid;
  logic        m_tready;
  logic [87:0] m_tdata;   // vector_position[3:0], tag_out[18:4], independent[19],
                          // is_residual[20], residual_index[24:21], in_basis[25],
                          // basis_index[41:26], residual_count[56:42],
                          // new_row_count[71:57], new_col_count[86:72], zero[87]
  logic        m_tuser;   // kind
  logic        m_tlast;   // last
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  gram_schmidt_rank_classifier u_top (.*);

  // model state of the classifier
  longint      work_vec [NVEC][NDIM];
  int unsigned row_tags [NVEC];
  int unsigned vec_fill;
  int unsigned elem_fill;
  cfg_t        regs;

  result_t     pending_results[$];
  int          error_count;
  int          words_sent;
  bit          calm;         // no idling in the last part of the run
  int          hold_off;     // long receiver stall, in cycles
  int          rx_burst;
  longint      prev_vec [NDIM];

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // generous fixed limit on the whole run
  initial begin
    #16000000;
    $display("tb: errors");
    $finish;
  end

  function automatic longint unsigned magnitude(longint x);
    return x < 0 ? longint'(0) - x : x;
  endfunction

  function automatic longint saturate(longint x);
    if (x > VSAT) return VSAT;
    if (x < -VSAT) return -VSAT;
    return x;
  endfunction

  // floor square root of a q.48 sum of squares
  function automatic longint unsigned root_floor(logic [127:0] s);
    logic [127:0] r, t;
    r = 0;
    for (int b = 42; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= s) r = t;
    end
    return longint'(r);
  endfunction

  // orthonormalize the loaded set in load order and queue the result words
  function automatic void classify_set();
    int unsigned dim, n, nres, ridx;
    bit          indep [NVEC];
    bit          resid [NVEC];
    longint      q [NDIM];
    logic [127:0] s, num;
    longint unsigned nrm, qa, sm, sh, sl, rcnt, bidx;
    longint      scale, t, p;
    bit          basis;
    result_t     r;
    dim = regs.dimension > NDIM ? NDIM : regs.dimension;
    n = vec_fill;
    nres = 0;
    for (int i = 0; i < n; i++) begin
      s = 0;
      for (int k = 0; k < dim; k++)
        s += 128'(magnitude(work_vec[i][k])) * 128'(magnitude(work_vec[i][k]));
      if (s < 128'(NORM_FLOOR)) begin
        for (int k = 0; k < dim; k++) q[k] = 0;
      end else begin
        nrm = root_floor(s);
        for (int k = 0; k < dim; k++) begin
          num = 128'(magnitude(work_vec[i][k])) << 24;
          qa = longint'(num / 128'(nrm));
          q[k] = work_vec[i][k] < 0 ? -longint'(qa) : longint'(qa);
        end
      end
      // remove the projection on q from every later vector
      for (int j = i + 1; j < n; j++) begin
        scale = 0;
        for (int k = 0; k < dim; k++) begin
          t = longint'((128'(magnitude(work_vec[j][k])) * 128'(magnitude(q[k]))) >> 24);
          scale += ((work_vec[j][k] < 0) != (q[k] < 0)) ? -t : t;
        end
        sm = magnitude(scale);
        if (sm > DOT_CEIL) continue;
        sh = sm >> 24;
        sl = sm & 64'hFFFFFF;
        for (int k = 0; k < dim; k++) begin
          qa = magnitude(q[k]);
          p = longint'(sh * qa + ((sl * qa) >> 24));
          if ((scale < 0) != (q[k] < 0)) p = -p;
          work_vec[j][k] = saturate(work_vec[j][k] - p);
        end
      end
      indep[i] = 0;
      for (int k = 0; k < dim; k++)
        if (magnitude(q[k]) > INDEP_FLOOR) indep[i] = 1;
      resid[i] = indep[i] && row_tags[i] >= regs.total_threshold;
      if (resid[i]) nres++;
    end
    rcnt = regs.initial_residual_count + nres;
    ridx = 0;
    for (int i = 0; i < n; i++) begin
      basis = !indep[i] && row_tags[i] < regs.total_threshold;
      bidx = 0;
      if (basis)
        bidx = row_tags[i] >= regs.column_count ? row_tags[i] + rcnt : row_tags[i];
      r = '0;
      r.vector_position = i[3:0];
      r.tag_out = row_tags[i][14:0];
      r.independent = indep[i];
      r.is_residual = resid[i];
      r.residual_index = resid[i] ? ridx[3:0] : 4'd0;
      r.in_basis = basis;
      r.basis_index = bidx[15:0];
      if (resid[i]) ridx++;
      pending_results = {pending_results, r};
    end
    r = '0;
    r.kind = 1;
    r.residual_count = rcnt[14:0];
    r.new_row_count = 15'(regs.row_count + rcnt);
    r.new_col_count = 15'(regs.column_count + rcnt);
    r.last = 1;
    pending_results = {pending_results, r};
    vec_fill = 0;
    elem_fill = 0;
  endfunction

  // one accepted element word
  function automatic void absorb_word(logic [31:0] elem, logic [14:0] tag, bit vend, bit send);
    int unsigned dim;
    dim = regs.dimension > NDIM ? NDIM : regs.dimension;
    if (vec_fill < NVEC) begin
      if (elem_fill < dim) begin
        work_vec[vec_fill][elem_fill] = longint'(signed'(elem));
        elem_fill++;
      end
      row_tags[vec_fill] = tag;
      if (vend || send) begin
        for (int k = elem_fill; k < NDIM; k++) work_vec[vec_fill][k] = 0;
        vec_fill++;
      end
    end
    if (vend || send) elem_fill = 0;
    if (send) classify_set();
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    error_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '0;
      got.kind = m_tuser;
      got.vector_position = m_tdata[3:0];
      got.tag_out = m_tdata[18:4];
      got.independent = m_tdata[19];
      got.is_residual = m_tdata[20];
      got.residual_index = m_tdata[24:21];
      got.in_basis = m_tdata[25];
      got.basis_index = m_tdata[41:26];
      got.residual_count = m_tdata[56:42];
      got.new_row_count = m_tdata[71:57];
      got.new_col_count = m_tdata[86:72];
      got.last = m_tlast;
      if (pending_results.size() == 0) begin
        report("unexpected word", 32'(got.vector_position), 0);
      end else begin
        want = pending_results.pop_front();
        if (got.kind != want.kind) report("kind", got.kind, want.kind);
        if (got.vector_position != want.vector_position)
          report("vector_position", got.vector_position, want.vector_position);
        if (got.tag_out != want.tag_out) report("tag_out", got.tag_out, want.tag_out);
        if (got.independent != want.independent)
          report("independent", got.independent, want.independent);
        if (got.is_residual != want.is_residual)
          report("is_residual", got.is_residual, want.is_residual);
        if (got.residual_index != want.residual_index)
          report("residual_index", got.residual_index, want.residual_index);
        if (got.in_basis != want.in_basis) report("in_basis", got.in_basis, want.in_basis);
        if (got.basis_index != want.basis_index)
          report("basis_index", got.basis_index, want.basis_index);
        if (got.residual_count != want.residual_count)
          report("residual_count", got.residual_count, want.residual_count);
        if (got.new_row_count != want.new_row_count)
          report("new_row_count", got.new_row_count, want.new_row_count);
        if (got.new_col_count != want.new_col_count)
          report("new_col_count", got.new_col_count, want.new_col_count);
        if (got.last != want.last) report("last", got.last, want.last);
      end
    end
  end

  // receiver: random stall bursts plus an optional long hold-off
  initial begin
    rx_burst = 0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        m_tready <= 0;
        hold_off--;
      end else if (rx_burst > 0) begin
        m_tready <= 0;
        rx_burst--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        m_tready <= 0;
        rx_burst = $urandom_range(1, 16) - 1;
      end else begin
        m_tready <= 1;
      end
    end
  end

  // send one element word and wait for it to be taken
  task automatic send_word(logic [31:0] elem, logic [14:0] tag, bit vend, bit send);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {1'b0, tag, elem};
    s_tlast <= vend;
    s_tuser <= send;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    absorb_word(elem, tag, vend, send);
    words_sent++;
  endtask

  // register write, only while the block is idle
  task automatic reg_write(int idx, int unsigned value);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 5'(idx * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      REG_DIMENSION:       regs.dimension = value[4:0];
      REG_TOTAL_THRESHOLD: regs.total_threshold = value[13:0];
      REG_COLUMN_COUNT:    regs.column_count = value[13:0];
      REG_ROW_COUNT:       regs.row_count = value[13:0];
      REG_INIT_RESIDUALS:  regs.initial_residual_count = value[13:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned dim, int unsigned thr, int unsigned col,
                            int unsigned rows, int unsigned init_res);
    reg_write(REG_DIMENSION, dim);
    reg_write(REG_TOTAL_THRESHOLD, thr);
    reg_write(REG_COLUMN_COUNT, col);
    reg_write(REG_ROW_COUNT, rows);
    reg_write(REG_INIT_RESIDUALS, init_res);
  endtask

  // wait until every result has left, then idle the bench before the next test
  task automatic drain();
    s_tvalid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [14:0] pick_tag();
    case ($urandom_range(0, 5))
      0: return 15'($urandom);
      1: return 15'h7FFF;
      default: return 15'($urandom_range(0, 40));
    endcase
  endfunction

  // one random set of vectors, the last word carries the set end
  task automatic send_random_set(int nvec);
    int unsigned dim, len, style, shift;
    logic [14:0] tag;
    logic [31:0] e;
    bit          fin;
    dim = regs.dimension > NDIM ? NDIM : regs.dimension;
    for (int v = 0; v < nvec; v++) begin
      len = dim == 0 ? $urandom_range(1, 3) : dim;
      if ($urandom_range(0, 6) == 0) len = $urandom_range(1, dim + 2);
      style = $urandom_range(0, 9);
      shift = $urandom_range(0, 3);
      tag = pick_tag();
      for (int k = 0; k < len; k++) begin
        case (style)
          0, 1, 2: e = $urandom;
          3:       e = 32'(int'($urandom_range(0, 600)) - 300);
          4:       e = 0;
          5, 6:    e = k < NDIM ? 32'(prev_vec[k] >>> shift) : $urandom;
          default: e = 32'(int'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
        endcase
        if (k < NDIM) prev_vec[k] = longint'(signed'(e));
        fin = (v == nvec - 1) && (k == len - 1);
        if ($urandom_range(0, 7) == 0) tag = pick_tag();
        send_word(e, tag, (k == len - 1) && (!fin || $urandom_range(0, 1)), fin);
      end
    end
  endtask

  // reset values: full dimension, one short vector
  task automatic test_reset_defaults();
    send_word(32'h0100_0000, 15'd3, 0, 0);
    send_word(32'hFF00_0000, 15'd3, 0, 0);
    send_word(32'h0000_0001, 15'd3, 0, 0);
    send_word(32'h7FFF_FFFF, 15'd9, 0, 1);
    drain();
  endtask

  // extreme elements, tiny norm, duplicate, short, long and retagged vectors
  task automatic test_field_extremes();
    set_config(3, 5, 3, 16383, 16383);
    send_word(32'h7FFF_FFFF, 15'h7FFF, 0, 0);
    send_word(32'h8000_0000, 15'h7FFF, 0, 0);
    send_word(32'h0000_0000, 15'h7FFF, 1, 0);
    send_word(32'h0000_0001, 15'd0, 0, 0);   // norm below floor
    send_word(32'hFFFF_FFFF, 15'd0, 0, 0);
    send_word(32'h0000_0000, 15'd0, 1, 0);
    send_word(32'h7FFF_FFFF, 15'd4, 0, 0);   // copy of the first: dependent
    send_word(32'h8000_0000, 15'd4, 0, 0);
    send_word(32'h0000_0000, 15'd4, 1, 0);
    send_word(32'h0123_4567, 15'd2, 1, 0);   // short vector
    send_word(32'h0100_0000, 15'd1, 0, 0);   // extra elements, tag changes
    send_word(32'h0000_0000, 15'd7, 0, 0);
    send_word(32'h0200_0000, 15'd7, 0, 0);
    send_word(32'h5555_5555, 15'd7, 0, 0);
    send_word(32'hAAAA_AAAA, 15'd6, 1, 1);
    drain();
  endtask

  // zero dimension makes every vector dependent
  task automatic test_dimension_zero();
    set_config(0, 16383, 0, 0, 0);
    send_word(32'h0100_0000, 15'd10, 1, 0);
    send_word(32'h0300_0000, 15'd16382, 0, 1);
    drain();
  endtask

  // more vectors than the store holds, dimension above the maximum
  task automatic test_vector_overflow();
    set_config(1, 0, 16383, 7, 1);
    for (int v = 0; v < 18; v++)
      send_word($urandom, pick_tag(), 1, v == 17);
    drain();
    set_config(31, 20, 10, 100, 0);
    send_random_set(2);
    drain();
  endtask

  // receiver holds off past the first set's compute while the second is offered
  task automatic test_backpressure();
    set_config(2, 8, 4, 30, 2);
    hold_off = 3000;
    send_random_set(4);
    send_random_set(3);
    drain();
  endtask

  task automatic random_config();
    int unsigned dim;
    case ($urandom_range(0, 7))
      0: dim = 16;
      1: dim = 31;
      2: dim = 0;
      3: dim = 1;
      default: dim = $urandom_range(1, 5);
    endcase
    set_config(dim,
               $urandom_range(0, 3) == 0 ? $urandom_range(0, 16383) : $urandom_range(0, 30),
               $urandom_range(0, 3) == 0 ? 16383 : $urandom_range(0, 30),
               $urandom_range(0, 16383),
               $urandom_range(0, 1) ? 0 : $urandom_range(0, 16383));
  endtask

  task automatic test_random_sets();
    int nvec, dim;
    while (words_sent < 195) begin
      if (words_sent > 160) calm = 1;
      random_config();
      repeat ($urandom_range(1, 3)) begin
        dim = regs.dimension > NDIM ? NDIM : regs.dimension;
        nvec = (dim <= 2 && $urandom_range(0, 4) == 0) ? 17 : $urandom_range(1, 6);
        if (dim > 8) nvec = $urandom_range(1, 3);
        send_random_set(nvec);
      end
      drain();
    end
  endtask

  initial begin
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tlast = 0;
    s_tuser = 0;
    m_tready = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    error_count = 0;
    words_sent = 0;
    calm = 0;
    hold_off = 0;
    vec_fill = 0;
    elem_fill = 0;
    regs = '0;
    regs.dimension = 16;
    for (int k = 0; k < NDIM; k++) prev_vec[k] = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    test_reset_defaults();
    test_field_extremes();
    test_dimension_zero();
    test_vector_overflow();
    test_backpressure();
    test_random_sets();

    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
